@@ sv/nls_pkg.sv @@
// Shared types, character codes and classification functions for the numeric literal scanner.
package nls_pkg;

  localparam int unsigned MaxLength = 255;
  localparam int unsigned CntW      = $clog2(MaxLength + 1);
  localparam int unsigned LenMax    = 255;

  localparam logic [7:0] ChX     = 8'h78;  // 'x'
  localparam logic [7:0] ChO     = 8'h6f;  // 'o'
  localparam logic [7:0] ChB     = 8'h62;  // 'b'
  localparam logic [7:0] ChDot   = 8'h2e;  // '.'
  localparam logic [7:0] ChELow  = 8'h65;  // 'e'
  localparam logic [7:0] ChEUp   = 8'h45;  // 'E'
  localparam logic [7:0] ChMinus = 8'h2d;  // '-'
  localparam logic [7:0] ChPlus  = 8'h2b;  // '+'
  localparam logic [7:0] ChZero  = 8'h30;  // '0'
  localparam logic [7:0] ChOne   = 8'h31;  // '1'
  localparam logic [7:0] ChSeven = 8'h37;  // '7'
  localparam logic [7:0] ChNine  = 8'h39;  // '9'
  localparam logic [7:0] ChALow  = 8'h61;  // 'a'
  localparam logic [7:0] ChFLow  = 8'h66;  // 'f'
  localparam logic [7:0] ChAUp   = 8'h41;  // 'A'
  localparam logic [7:0] ChFUp   = 8'h46;  // 'F'

  typedef enum logic [1:0] {
    RDX_BIN = 2'd0,
    RDX_OCT = 2'd1,
    RDX_DEC = 2'd2,
    RDX_HEX = 2'd3
  } radix_e;

  typedef enum logic [3:0] {
    PH_IDLE    = 4'd0,
    PH_SIGNS   = 4'd1,
    PH_ZERO    = 4'd2,
    PH_DIGITS  = 4'd3,
    PH_DOT     = 4'd4,
    PH_FRAC    = 4'd5,
    PH_EPEND   = 4'd6,
    PH_EXPSIGN = 4'd7,
    PH_EXPDIG  = 4'd8
  } phase_e;

  typedef struct packed {
    logic [7:0] character;
    logic       begin_req;
    logic       end_of_text;
  } item_t;

  typedef struct packed {
    logic [7:0] token_length;
    radix_e     radix;
    logic       exponent_error;
  } result_t;

  function automatic logic is_dec(input logic [7:0] c);
    is_dec = (c >= ChZero) && (c <= ChNine);
  endfunction

  function automatic logic is_exp(input logic [7:0] c);
    is_exp = (c == ChELow) || (c == ChEUp);
  endfunction

  function automatic logic radix_digit(input logic [7:0] c, input radix_e r);
    unique case (r)
      RDX_BIN: radix_digit = (c == ChZero) || (c == ChOne);
      RDX_OCT: radix_digit = (c >= ChZero) && (c <= ChSeven);
      RDX_DEC: radix_digit = is_dec(c);
      RDX_HEX: radix_digit = is_dec(c) || ((c >= ChALow) && (c <= ChFLow)) ||
                             ((c >= ChAUp) && (c <= ChFUp));
      default: radix_digit = 1'b0;
    endcase
  endfunction

endpackage

@@ sv/numeric_literal_scanner_top.sv @@
// Numeric literal scanner: input register, scan core and result register.
// A result is registered in the result register as the character that ends it leaves the input register.
// Throughput: one character per cycle unless a waiting result stalls; the scan state update is one combinational step.
// A waiting result stalls the input register only while out_ready_i is low.
// Reset (rst_ni low, asynchronous): both registers empty, scan idle, radix decimal, count zero.
module numeric_literal_scanner_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] character_i,
  input  logic       begin_req_i,
  input  logic       end_of_text_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] token_length_o,
  output logic [1:0] radix_o,
  output logic       exponent_error_o
);

  nls_pkg::item_t   in_item;
  nls_pkg::item_t   item;
  logic             item_valid;
  logic             advance;
  logic             fire;
  nls_pkg::result_t result;

  logic             out_valid_q, out_valid_d;
  nls_pkg::result_t out_q;

  assign in_item.character   = character_i;
  assign in_item.begin_req   = begin_req_i;
  assign in_item.end_of_text = end_of_text_i;

  // Advance the held character whenever the result register can take a result.
  assign advance = !out_valid_q || out_ready_i;

  nls_in_stage u_in_stage (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_item_i    (in_item),
    .advance_i    (advance),
    .item_valid_o (item_valid),
    .item_o       (item)
  );

  nls_scan_core u_scan_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (item_valid && advance),
    .item_i   (item),
    .fire_o   (fire),
    .result_o (result)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = fire;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_q <= result;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign token_length_o   = out_q.token_length;
  assign radix_o          = out_q.radix;
  assign exponent_error_o = out_q.exponent_error;

endmodule

@@ sv/nls_in_stage.sv @@
// Input register stage: captures one character item per transfer.
module nls_in_stage (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  nls_pkg::item_t in_item_i,
  input  logic          advance_i,
  output logic          item_valid_o,
  output nls_pkg::item_t item_o
);

  logic           valid_q, valid_d;
  nls_pkg::item_t item_q;

  assign in_ready_o   = !valid_q || advance_i;
  assign item_valid_o = valid_q;
  assign item_o       = item_q;

  always_comb begin
    valid_d = valid_q;
    if (in_ready_o) begin
      valid_d = in_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload needs no reset.
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q <= in_item_i;
    end
  end

endmodule

@@ sv/nls_scan_core.sv @@
// Scan state registers and the per-character phase update.
module nls_scan_core (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  nls_pkg::item_t   item_i,
  output logic             fire_o,
  output nls_pkg::result_t result_o
);

  nls_pkg::phase_e          phase_q, phase_d;
  nls_pkg::radix_e          radix_q, radix_d;
  logic [nls_pkg::CntW-1:0] count_q, count_d;
  logic                     err_q, err_d;

  nls_pkg::phase_e          ph;
  nls_pkg::radix_e          rdx;
  logic [nls_pkg::CntW-1:0] cnt;
  logic [nls_pkg::CntW:0]   sum;
  logic [1:0]               add;
  logic                     err;
  logic                     fin;
  logic                     quiet;
  logic [7:0]               c;

  always_comb begin
    c     = item_i.character;
    ph    = item_i.begin_req ? nls_pkg::PH_SIGNS : phase_q;
    rdx   = item_i.begin_req ? nls_pkg::RDX_DEC : radix_q;
    cnt   = item_i.begin_req ? '0 : count_q;
    err   = item_i.begin_req ? 1'b0 : err_q;
    add   = 2'd0;
    fin   = 1'b0;
    quiet = 1'b0;
    sum   = '0;

    unique case (ph)
      nls_pkg::PH_IDLE: quiet = 1'b1;
      nls_pkg::PH_SIGNS: begin
        if (c == nls_pkg::ChPlus || c == nls_pkg::ChMinus) begin
          add = 2'd1;
        end else if (c == nls_pkg::ChZero) begin
          add = 2'd1;
          ph  = nls_pkg::PH_ZERO;
        end else if (nls_pkg::is_dec(c)) begin
          add = 2'd1;
          ph  = nls_pkg::PH_DIGITS;
        end else if (c == nls_pkg::ChDot) begin
          ph = nls_pkg::PH_DOT;
        end else if (nls_pkg::is_exp(c)) begin
          ph = nls_pkg::PH_EPEND;
        end else begin
          fin = 1'b1;
        end
      end
      nls_pkg::PH_ZERO: begin
        if (c == nls_pkg::ChX || c == nls_pkg::ChO || c == nls_pkg::ChB) begin
          add = 2'd1;
          ph  = nls_pkg::PH_DIGITS;
          if (c == nls_pkg::ChX) begin
            rdx = nls_pkg::RDX_HEX;
          end else if (c == nls_pkg::ChO) begin
            rdx = nls_pkg::RDX_OCT;
          end else begin
            rdx = nls_pkg::RDX_BIN;
          end
        end else if (nls_pkg::is_dec(c)) begin
          add = 2'd1;
          ph  = nls_pkg::PH_DIGITS;
        end else if (c == nls_pkg::ChDot) begin
          ph = nls_pkg::PH_DOT;
        end else if (nls_pkg::is_exp(c)) begin
          ph = nls_pkg::PH_EPEND;
        end else begin
          fin = 1'b1;
        end
      end
      nls_pkg::PH_DIGITS: begin
        if (nls_pkg::radix_digit(c, rdx)) begin
          add = 2'd1;
        end else if (rdx == nls_pkg::RDX_DEC && c == nls_pkg::ChDot) begin
          ph = nls_pkg::PH_DOT;
        end else if (rdx == nls_pkg::RDX_DEC && nls_pkg::is_exp(c)) begin
          ph = nls_pkg::PH_EPEND;
        end else begin
          fin = 1'b1;
        end
      end
      nls_pkg::PH_DOT: begin
        // The dot is counted only once a fraction digit confirms it.
        if (nls_pkg::is_dec(c)) begin
          add = 2'd2;
          ph  = nls_pkg::PH_FRAC;
        end else begin
          fin = 1'b1;
        end
      end
      nls_pkg::PH_FRAC: begin
        if (nls_pkg::is_dec(c)) begin
          add = 2'd1;
        end else if (nls_pkg::is_exp(c)) begin
          ph = nls_pkg::PH_EPEND;
        end else begin
          fin = 1'b1;
        end
      end
      nls_pkg::PH_EPEND: begin
        if (nls_pkg::is_dec(c)) begin
          add = 2'd2;
          ph  = nls_pkg::PH_EXPDIG;
        end else if (c == nls_pkg::ChMinus) begin
          add = 2'd2;
          ph  = nls_pkg::PH_EXPSIGN;
        end else begin
          fin = 1'b1;
        end
      end
      nls_pkg::PH_EXPSIGN: begin
        if (nls_pkg::is_dec(c)) begin
          add = 2'd1;
          ph  = nls_pkg::PH_EXPDIG;
        end else begin
          err = 1'b1;
          fin = 1'b1;
        end
      end
      nls_pkg::PH_EXPDIG: begin
        if (nls_pkg::is_dec(c)) begin
          add = 2'd1;
        end else begin
          fin = 1'b1;
        end
      end
      default: begin
        ph    = nls_pkg::PH_IDLE;
        quiet = 1'b1;
      end
    endcase

    // Saturating count.
    sum = {1'b0, cnt} + {{(nls_pkg::CntW - 1){1'b0}}, add};
    if (sum > (nls_pkg::CntW + 1)'(nls_pkg::MaxLength)) begin
      cnt = nls_pkg::CntW'(nls_pkg::MaxLength);
    end else begin
      cnt = sum[nls_pkg::CntW-1:0];
    end

    if (!fin && !quiet && item_i.end_of_text) begin
      if (ph == nls_pkg::PH_EXPSIGN) begin
        err = 1'b1;
      end
      fin = 1'b1;
    end
    if (fin) begin
      ph = nls_pkg::PH_IDLE;
    end

    phase_d = phase_q;
    radix_d = radix_q;
    count_d = count_q;
    err_d   = err_q;
    if (step_i) begin
      phase_d = ph;
      radix_d = rdx;
      count_d = cnt;
      err_d   = err;
    end
  end

  always_comb begin
    fire_o = step_i && fin;
    if (cnt > nls_pkg::CntW'(nls_pkg::LenMax)) begin
      result_o.token_length = 8'(nls_pkg::LenMax);
    end else begin
      result_o.token_length = cnt[7:0];
    end
    result_o.radix          = rdx;
    result_o.exponent_error = err;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= nls_pkg::PH_IDLE;
      radix_q <= nls_pkg::RDX_DEC;
      count_q <= '0;
      err_q   <= 1'b0;
    end else begin
      phase_q <= phase_d;
      radix_q <= radix_d;
      count_q <= count_d;
      err_q   <= err_d;
    end
  end

endmodule

@@ dv/tb_numeric_literal_scanner_top.sv @@
// Self-checking testbench for the numeric literal scanner: character stream in, token checks out.
`timescale 1ns / 100ps

module tb_numeric_literal_scanner_top;

  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned IdlePct    = 38;
  localparam int unsigned CalmFrom   = 150;
  localparam int unsigned CalmTo     = 350;
  localparam int unsigned HoldAt     = 450;
  localparam int unsigned HoldLen    = 100;
  localparam int unsigned PauseAt    = 700;
  localparam int unsigned LitChars   = 800;
  localparam int unsigned DrainWait  = 8;

  logic       clk_i         = 1'b0;
  logic       rst_ni        = 1'b0;
  logic       in_valid_i    = 1'b0;
  logic       in_ready_o;
  logic [7:0] character_i   = 8'h00;
  logic       begin_req_i   = 1'b0;
  logic       end_of_text_i = 1'b0;
  logic       out_valid_o;
  logic       out_ready_i   = 1'b0;
  logic [7:0] token_length_o;
  logic [1:0] radix_o;
  logic       exponent_error_o;

  numeric_literal_scanner_top dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .character_i     (character_i),
    .begin_req_i     (begin_req_i),
    .end_of_text_i   (end_of_text_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .token_length_o  (token_length_o),
    .radix_o         (radix_o),
    .exponent_error_o(exponent_error_o)
  );

  always #10 clk_i = ~clk_i;

  nls_pkg::item_t   char_feed[$];
  nls_pkg::result_t pending_tokens[$];

  // Scanner shadow state
  nls_pkg::phase_e sc_phase = nls_pkg::PH_IDLE;
  nls_pkg::radix_e sc_radix = nls_pkg::RDX_DEC;
  int unsigned     sc_count = 0;
  logic            sc_err   = 1'b0;

  int unsigned fed         = 0;
  int unsigned checked     = 0;
  int unsigned mismatches  = 0;
  int unsigned cycles      = 0;
  int unsigned lit_chars   = 0;
  int unsigned lit_count   = 0;
  int unsigned full_tokens = 0;
  int unsigned err_tokens  = 0;
  int unsigned radix_seen[4];
  int unsigned stall_left  = 0;
  bit          held        = 1'b0;
  bit          paused      = 1'b0;
  bit          drain_wait  = 1'b0;
  logic        calm;

  assign calm = (fed >= CalmFrom) && (fed < CalmTo);

  task automatic flag_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    mismatches++;
  endtask

  function automatic bit dec_digit(input logic [7:0] c);
    return (c >= nls_pkg::ChZero) && (c <= nls_pkg::ChNine);
  endfunction

  function automatic bit fits_radix(input logic [7:0] c, input nls_pkg::radix_e r);
    case (r)
      nls_pkg::RDX_BIN: return (c == nls_pkg::ChZero) || (c == nls_pkg::ChOne);
      nls_pkg::RDX_OCT: return (c >= nls_pkg::ChZero) && (c <= nls_pkg::ChSeven);
      nls_pkg::RDX_HEX: return dec_digit(c) ||
                               ((c >= nls_pkg::ChALow) && (c <= nls_pkg::ChFLow)) ||
                               ((c >= nls_pkg::ChAUp) && (c <= nls_pkg::ChFUp));
      default: return dec_digit(c);
    endcase
  endfunction

  function automatic void grow(input int unsigned n);
    sc_count = (sc_count + n > nls_pkg::MaxLength) ? nls_pkg::MaxLength : sc_count + n;
  endfunction

  // Advance the shadow scanner by one character and queue the token it closes, if any.
  task automatic scan_char(input logic [7:0] c, input logic bgn, input logic eot);
    bit               closed;
    nls_pkg::phase_e  tail;
    nls_pkg::result_t tok;
    closed = 1'b0;
    if (bgn) begin
      sc_phase = nls_pkg::PH_SIGNS;
      sc_radix = nls_pkg::RDX_DEC;
      sc_count = 0;
      sc_err   = 1'b0;
    end
    // where a decimal number may continue: fraction point or exponent mark
    tail = (c == nls_pkg::ChDot) ? nls_pkg::PH_DOT :
           ((c == nls_pkg::ChELow) || (c == nls_pkg::ChEUp)) ? nls_pkg::PH_EPEND :
           nls_pkg::PH_IDLE;
    case (sc_phase)
      nls_pkg::PH_IDLE: return;
      nls_pkg::PH_SIGNS: begin
        if ((c == nls_pkg::ChPlus) || (c == nls_pkg::ChMinus)) grow(1);
        else if (c == nls_pkg::ChZero) begin
          grow(1);
          sc_phase = nls_pkg::PH_ZERO;
        end else if (dec_digit(c)) begin
          grow(1);
          sc_phase = nls_pkg::PH_DIGITS;
        end else if (tail != nls_pkg::PH_IDLE) sc_phase = tail;
        else closed = 1'b1;
      end
      nls_pkg::PH_ZERO: begin
        if ((c == nls_pkg::ChX) || (c == nls_pkg::ChO) || (c == nls_pkg::ChB)) begin
          grow(1);
          sc_radix = (c == nls_pkg::ChX) ? nls_pkg::RDX_HEX :
                     (c == nls_pkg::ChO) ? nls_pkg::RDX_OCT : nls_pkg::RDX_BIN;
          sc_phase = nls_pkg::PH_DIGITS;
        end else if (dec_digit(c)) begin
          grow(1);
          sc_phase = nls_pkg::PH_DIGITS;
        end else if (tail != nls_pkg::PH_IDLE) sc_phase = tail;
        else closed = 1'b1;
      end
      nls_pkg::PH_DIGITS: begin
        if (fits_radix(c, sc_radix)) grow(1);
        else if ((sc_radix == nls_pkg::RDX_DEC) && (tail != nls_pkg::PH_IDLE)) sc_phase = tail;
        else closed = 1'b1;
      end
      nls_pkg::PH_DOT: begin
        // point and first fraction digit are counted together
        if (dec_digit(c)) begin
          grow(2);
          sc_phase = nls_pkg::PH_FRAC;
        end else closed = 1'b1;
      end
      nls_pkg::PH_FRAC: begin
        if (dec_digit(c)) grow(1);
        else if (tail == nls_pkg::PH_EPEND) sc_phase = nls_pkg::PH_EPEND;
        else closed = 1'b1;
      end
      nls_pkg::PH_EPEND: begin
        if (dec_digit(c)) begin
          grow(2);
          sc_phase = nls_pkg::PH_EXPDIG;
        end else if (c == nls_pkg::ChMinus) begin
          grow(2);
          sc_phase = nls_pkg::PH_EXPSIGN;
        end else closed = 1'b1;
      end
      nls_pkg::PH_EXPSIGN: begin
        if (dec_digit(c)) begin
          grow(1);
          sc_phase = nls_pkg::PH_EXPDIG;
        end else begin
          sc_err = 1'b1;
          closed = 1'b1;
        end
      end
      nls_pkg::PH_EXPDIG: begin
        if (dec_digit(c)) grow(1);
        else closed = 1'b1;
      end
      default: begin
        sc_phase = nls_pkg::PH_IDLE;
        return;
      end
    endcase
    if (!closed && eot) begin
      if (sc_phase == nls_pkg::PH_EXPSIGN) sc_err = 1'b1;
      closed = 1'b1;
    end
    if (closed) begin
      tok.token_length   = 8'((sc_count > nls_pkg::LenMax) ? nls_pkg::LenMax : sc_count);
      tok.radix          = sc_radix;
      tok.exponent_error = sc_err;
      pending_tokens.push_back(tok);
      radix_seen[sc_radix]++;
      if (sc_count >= nls_pkg::LenMax) full_tokens++;
      if (sc_err) err_tokens++;
      sc_phase = nls_pkg::PH_IDLE;
    end
  endtask

  task automatic push_char(input logic [7:0] c, input logic bgn, input logic eot);
    nls_pkg::item_t it;
    it.character   = c;
    it.begin_req   = bgn;
    it.end_of_text = eot;
    char_feed.push_back(it);
  endtask

  task automatic push_text(input string s, input bit eot_last);
    for (int i = 0; i < s.len(); i++)
      push_char(s[i], i == 0, eot_last && (i == s.len() - 1));
  endtask

  function automatic logic [7:0] any_digit(input nls_pkg::radix_e r);
    case (r)
      nls_pkg::RDX_BIN: return nls_pkg::ChZero + 8'($urandom_range(0, 1));
      nls_pkg::RDX_OCT: return nls_pkg::ChZero + 8'($urandom_range(0, 7));
      nls_pkg::RDX_DEC: return nls_pkg::ChZero + 8'($urandom_range(0, 9));
      default: begin
        case ($urandom_range(0, 2))
          0:       return nls_pkg::ChZero + 8'($urandom_range(0, 9));
          1:       return nls_pkg::ChALow + 8'($urandom_range(0, 5));
          default: return nls_pkg::ChAUp + 8'($urandom_range(0, 5));
        endcase
      end
    endcase
  endfunction

  // Mostly well-formed literals with random content; some fraction or exponent
  // marks left without digits, a random closing byte, then a little stray text.
  task automatic emit_literal();
    logic [7:0]      txt[$];
    nls_pkg::radix_e r;
    int              kind;
    int              n;
    bit              eot_last;
    r        = nls_pkg::RDX_DEC;
    eot_last = 1'b0;
    if ($urandom_range(0, 3) == 0)
      repeat ($urandom_range(1, 3))
        txt.push_back($urandom_range(0, 1) ? nls_pkg::ChPlus : nls_pkg::ChMinus);
    kind = $urandom_range(0, 9);
    if (kind < 5) begin
      txt.push_back(nls_pkg::ChZero);
      case (kind)
        0, 1: begin
          txt.push_back(nls_pkg::ChX);
          r = nls_pkg::RDX_HEX;
        end
        2: begin
          txt.push_back(nls_pkg::ChO);
          r = nls_pkg::RDX_OCT;
        end
        3: begin
          txt.push_back(nls_pkg::ChB);
          r = nls_pkg::RDX_BIN;
        end
        default: ;
      endcase
    end
    // now and then a literal long enough to saturate the length
    n = ($urandom_range(0, 39) == 0) ? $urandom_range(240, 300) : $urandom_range(0, 5);
    repeat (n) txt.push_back(any_digit(r));
    if (r == nls_pkg::RDX_DEC) begin
      if ($urandom_range(0, 2) == 0) begin
        txt.push_back(nls_pkg::ChDot);
        repeat ($urandom_range(0, 3)) txt.push_back(any_digit(nls_pkg::RDX_DEC));
      end
      if ($urandom_range(0, 2) == 0) begin
        txt.push_back($urandom_range(0, 1) ? nls_pkg::ChELow : nls_pkg::ChEUp);
        if ($urandom_range(0, 1)) txt.push_back(nls_pkg::ChMinus);
        repeat ($urandom_range(0, 3)) txt.push_back(any_digit(nls_pkg::RDX_DEC));
      end
    end
    case ($urandom_range(0, 3))
      0:       eot_last = 1'b1;
      1, 2:    txt.push_back(8'($urandom_range(0, 255)));
      default: ;
    endcase
    if (txt.size() != 0) lit_count++;
    foreach (txt[i]) push_char(txt[i], i == 0, eot_last && (i == txt.size() - 1));
    lit_chars += txt.size();
    repeat ($urandom_range(0, 2))
      push_char(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0, $urandom_range(0, 9) == 0);
  endtask

  // Sender: offer queued characters, predict on each transfer
  always @(posedge clk_i or negedge rst_ni) begin : feed_proc
    nls_pkg::item_t nxt;
    bit             busy;
    if (!rst_ni) begin
      in_valid_i    <= 1'b0;
      character_i   <= 8'h00;
      begin_req_i   <= 1'b0;
      end_of_text_i <= 1'b0;
    end else begin
      busy = in_valid_i;
      if (in_valid_i && in_ready_o) begin
        scan_char(character_i, begin_req_i, end_of_text_i);
        fed++;
        busy = 1'b0;
      end
      if (!paused && (fed >= PauseAt)) begin
        paused     = 1'b1;
        drain_wait = 1'b1;
      end
      if (drain_wait && (pending_tokens.size() == 0)) drain_wait = 1'b0;
      if (!busy) begin
        if ((char_feed.size() != 0) && !drain_wait &&
            (calm || ($urandom_range(0, 99) >= IdlePct))) begin
          nxt = char_feed.pop_front();
          in_valid_i    <= 1'b1;
          character_i   <= nxt.character;
          begin_req_i   <= nxt.begin_req;
          end_of_text_i <= nxt.end_of_text;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Receiver: check each token transfer against the oldest prediction
  always @(posedge clk_i or negedge rst_ni) begin : sink_proc
    nls_pkg::result_t want;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (pending_tokens.size() == 0) begin
          flag_mismatch($sformatf("token with none expected: len %0d radix %0d err %0b",
                                  token_length_o, radix_o, exponent_error_o));
        end else begin
          want = pending_tokens.pop_front();
          checked++;
          if (token_length_o !== want.token_length)
            flag_mismatch($sformatf("token %0d length %0d, want %0d",
                                    checked, token_length_o, want.token_length));
          if (radix_o !== want.radix)
            flag_mismatch($sformatf("token %0d radix %0d, want %0d",
                                    checked, radix_o, want.radix));
          if (exponent_error_o !== want.exponent_error)
            flag_mismatch($sformatf("token %0d exponent error %0b, want %0b",
                                    checked, exponent_error_o, want.exponent_error));
        end
      end
      if (!held && (fed >= HoldAt)) begin
        held       = 1'b1;
        stall_left = HoldLen;
      end
      if (stall_left != 0) begin
        stall_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= calm || ($urandom_range(0, 99) >= IdlePct);
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CycleLimit) begin
      $display("TIMEOUT after %0d cycles: %0d characters left, %0d tokens outstanding",
               cycles, char_feed.size(), pending_tokens.size());
      $display("tb_numeric_literal_scanner_top failed");
      $finish;
    end
  end

  initial begin
    // directed: prefixes, signs, fraction, exponent, lookahead misses, restarts
    push_text("-0xF;", 1'b0);
    push_text("0b", 1'b1);
    push_text("0o7.", 1'b0);
    push_text("1.5e-3", 1'b1);
    push_text("2e-z", 1'b0);
    push_text("9E-", 1'b1);
    push_text("4.", 1'b1);
    push_text("z", 1'b0);
    push_text("12", 1'b0);
    push_text("3 ", 1'b0);
    while (lit_chars < LitChars) emit_literal();

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    while ((char_feed.size() != 0) || in_valid_i) @(posedge clk_i);
    while (pending_tokens.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
    if (pending_tokens.size() != 0)
      flag_mismatch($sformatf("%0d tokens never arrived", pending_tokens.size()));

    $display("Covered %0d characters (%0d literals, %0d literal chars), %0d tokens checked",
             fed, lit_count, lit_chars, checked);
    $display("Token mix: bin %0d oct %0d dec %0d hex %0d, %0d saturated, %0d exponent errors",
             radix_seen[nls_pkg::RDX_BIN], radix_seen[nls_pkg::RDX_OCT],
             radix_seen[nls_pkg::RDX_DEC], radix_seen[nls_pkg::RDX_HEX],
             full_tokens, err_tokens);
    if (mismatches == 0) $display("tb_numeric_literal_scanner_top passed");
    else $display("tb_numeric_literal_scanner_top failed");
    $finish;
  end

endmodule
